// ----- rtl/hopfield_associative_memory_top_assert.svh -----
// Assertion macros shared by the checker of the associative memory block.
// Depends on nothing; the including module supplies i_clk and i_rst_n.
`ifndef HOPFIELD_ASSOCIATIVE_MEMORY_TOP_ASSERT_SVH
`define HOPFIELD_ASSOCIATIVE_MEMORY_TOP_ASSERT_SVH

// Consequence must hold in the same cycle as the condition.
`define HOP_ASSERT_SAME(label, cond, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (cons)) \
        else $error(msg);

// Consequence must hold in the cycle after the condition.
`define HOP_ASSERT_NEXT(label, cond, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/hop_pkg.sv -----
// Shared types and constants of the associative memory block.
// Used by the cell, adder tree, top level and checker; depends on nothing.
`timescale 1ns / 1ps

package hop_pkg;

    // Default sizes handed down from the top level.
    localparam int NEURONS_DEF     = 64;
    localparam int WEIGHT_BITS_DEF = 8;

    // Fixed port widths.
    localparam int OP_W       = 2;
    localparam int PAT_W      = 64;
    localparam int COUNT_W    = 8;
    localparam int ACTIVE_W   = 7;
    localparam int SWEEP_W    = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // Configuration register indexes and reset values.
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SWEEPS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd2;

    localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 7'd64;
    localparam logic [SWEEP_W-1:0]  SWEEPS_RESET = 8'd1;

    // Update modes.
    localparam logic MODE_ASYNC = 1'b0;
    localparam logic MODE_SYNC  = 1'b1;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR  = 2'd0,
        OP_STORE  = 2'd1,
        OP_RECALL = 2'd2,
        OP_NOP    = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_STORE,
        ST_RECALL
    } t_state;

    // Per-cycle control seen by every cell for the row in its read-data stage.
    typedef struct packed {
        logic clr;
        logic store;
        logic recall;
        logic p_row;
    } t_cell_ctrl;

endpackage

// ----- rtl/hop_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module hop_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/hop_cell.sv -----
// One neuron column: holds the weights w[i][j] of its neuron j for all rows i.
// Depends on hop_pkg and hop_ram.
`timescale 1ns / 1ps

module hop_cell import hop_pkg::*; #(
    parameter int NEURONS     = NEURONS_DEF,
    parameter int WEIGHT_BITS = WEIGHT_BITS_DEF,
    parameter int INDEX       = 0
) (
    input  logic                       i_clk,
    input  t_cell_ctrl                 i_ctrl,
    input  logic [$clog2(NEURONS)-1:0] i_rd_row,
    input  logic [$clog2(NEURONS)-1:0] i_row_b,
    input  logic                       i_active,
    input  logic                       i_p_bit,
    input  logic                       i_s_bit,
    output logic signed [WEIGHT_BITS:0] o_term,
    output logic                       o_clip
);

    localparam int RW = $clog2(NEURONS);
    localparam int TW = WEIGHT_BITS + 1;
    localparam logic [RW-1:0] SELF = RW'(INDEX);
    localparam logic signed [WEIGHT_BITS-1:0] W_MAX = {1'b0, {(WEIGHT_BITS-1){1'b1}}};
    localparam logic signed [WEIGHT_BITS-1:0] W_MIN = {1'b1, {(WEIGHT_BITS-1){1'b0}}};
    localparam logic signed [WEIGHT_BITS-1:0] W_ONE = WEIGHT_BITS'(1);

    logic [WEIGHT_BITS-1:0]        w_rd_raw;
    logic signed [WEIGHT_BITS-1:0] w_wt;
    logic signed [WEIGHT_BITS-1:0] w_upd;
    logic [WEIGHT_BITS-1:0]        w_wdata;
    logic signed [TW-1:0]          w_ext;
    logic                          w_lane;
    logic                          w_inc;
    logic                          w_sat;
    logic                          w_we;
    logic signed [TW-1:0]          r_term;

    hop_ram #(
        .WIDTH (WEIGHT_BITS),
        .DEPTH (NEURONS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (i_row_b),
        .i_wdata (w_wdata),
        .i_raddr (i_rd_row),
        .o_rdata (w_rd_raw)
    );

    // The diagonal and inactive neurons never take part.
    assign w_wt   = $signed(w_rd_raw);
    assign w_lane = i_active && (i_row_b != SELF);

    // Hebbian update: +1 when both bits agree, -1 otherwise, clipped at the range.
    assign w_inc   = ~(i_ctrl.p_row ^ i_p_bit);
    assign w_sat   = w_inc ? (w_wt == W_MAX) : (w_wt == W_MIN);
    assign w_upd   = w_inc ? (w_wt + W_ONE) : (w_wt - W_ONE);
    assign w_we    = i_ctrl.clr || (i_ctrl.store && w_lane);
    assign w_wdata = i_ctrl.clr ? '0 : (w_sat ? w_wt : w_upd);
    assign o_clip  = i_ctrl.store && w_lane && w_sat;

    // Drive contribution of this neuron to the row under recall.
    assign w_ext = {w_wt[WEIGHT_BITS-1], w_wt};

    always_ff @(posedge i_clk) begin
        if (i_ctrl.recall && w_lane) begin
            r_term <= i_s_bit ? w_ext : -w_ext;
        end else begin
            r_term <= '0;
        end
    end

    assign o_term = r_term;

endmodule

// ----- rtl/hop_sum_tree.sv -----
// Registered adder tree that sums the drive terms of all cells for one row.
// Depends on hop_pkg.
`timescale 1ns / 1ps

module hop_sum_tree import hop_pkg::*; #(
    parameter int NEURONS     = NEURONS_DEF,
    parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_vld,
    input  logic [$clog2(NEURONS)-1:0] i_tag,
    input  logic signed [WEIGHT_BITS:0] i_terms [NEURONS],
    output logic                       o_vld,
    output logic [$clog2(NEURONS)-1:0] o_tag,
    output logic signed [WEIGHT_BITS+$clog2(NEURONS):0] o_sum
);

    localparam int LEVELS = $clog2(NEURONS);
    localparam int LEAVES = 1 << LEVELS;
    localparam int TW     = WEIGHT_BITS + 1;
    localparam int SW     = TW + LEVELS;

    logic signed [SW-1:0] w_leaf [LEAVES];
    logic signed [SW-1:0] r_node [1:LEAVES-1];
    logic [LEVELS-1:0]    r_vld;
    logic [LEVELS-1:0]    r_tag [LEVELS];

    // Sign-extended leaves, padded with zeros up to a power of two.
    for (genvar k = 0; k < LEAVES; k++) begin : g_leaf
        if (k < NEURONS) begin : g_used
            assign w_leaf[k] = {{LEVELS{i_terms[k][TW-1]}}, i_terms[k]};
        end else begin : g_pad
            assign w_leaf[k] = '0;
        end
    end

    // One register level per tree level; node 1 is the root.
    for (genvar k = 1; k < LEAVES; k++) begin : g_node
        if (2 * k >= LEAVES) begin : g_bottom
            always_ff @(posedge i_clk) begin
                r_node[k] <= w_leaf[2*k-LEAVES] + w_leaf[2*k+1-LEAVES];
            end
        end else begin : g_inner
            always_ff @(posedge i_clk) begin
                r_node[k] <= r_node[2*k] + r_node[2*k+1];
            end
        end
    end

    // Valid and row tag travel alongside the sum.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LEVELS-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag[0] <= i_tag;
        for (int k = 1; k < LEVELS; k++) begin
            r_tag[k] <= r_tag[k-1];
        end
    end

    assign o_vld = r_vld[LEVELS-1];
    assign o_tag = r_tag[LEVELS-1];
    assign o_sum = r_node[1];

endmodule

// ----- rtl/hopfield_associative_memory_top.sv -----
// Top level of the Hopfield associative memory: sequencer, cell row and adder tree.
// Depends on hop_pkg, hop_cell, hop_ram and hop_sum_tree.
`timescale 1ns / 1ps

// A transaction is accepted when start is high and busy is low; its result is
// shown for exactly one cycle with o_done and cannot be held off. The weights
// live in one column RAM per neuron cell, so one weight row is handled per
// cycle, except in asynchronous recall, where each neuron waits for the
// previous one to leave the RAM read, term and adder tree stages. After reset
// the block runs a clearing pass over all NEURONS rows with busy high.
// No-op and a recall with zero sweeps answer in the next cycle.
module hopfield_associative_memory_top import hop_pkg::*; #(
    parameter int NEURONS     = NEURONS_DEF,
    parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [OP_W-1:0]       i_operation,
    input  logic [PAT_W-1:0]      i_pattern_bits,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_done,
    output logic [PAT_W-1:0]      o_result_bits,
    output logic [COUNT_W-1:0]    o_patterns_stored,
    output logic                  o_weight_saturated
);

    localparam int RW = $clog2(NEURONS);
    localparam int CW = $clog2(NEURONS + 1);
    localparam int TW = WEIGHT_BITS + 1;
    localparam int SW = TW + RW;

    t_state r_state, n_state;

    logic [ACTIVE_W-1:0] r_active;
    logic [SWEEP_W-1:0]  r_sweeps;
    logic                r_mode;

    logic [NEURONS-1:0]  r_p;
    logic [NEURONS-1:0]  r_s;
    logic [NEURONS-1:0]  r_nx;
    logic [NEURONS-1:0]  r_res;
    logic [CW-1:0]       r_iss;
    logic [CW-1:0]       r_got;
    logic [SWEEP_W-1:0]  r_sweep;
    logic                r_b_vld;
    logic [RW-1:0]       r_b_row;
    logic                r_b_p;
    logic                r_c_vld;
    logic [RW-1:0]       r_c_row;
    logic [COUNT_W-1:0]  r_count;
    logic                r_clip;
    logic                r_stb;

    logic [ACTIVE_W-1:0] w_live;
    logic [CW-1:0]       w_n;
    logic [NEURONS-1:0]  w_mask;
    logic [NEURONS-1:0]  w_pat;
    logic                w_acc;
    t_op                 w_op;
    logic                w_clearing;
    logic                w_issue;
    logic                w_clear_last;
    logic                w_store_end;
    logic                w_sweep_end;
    logic                w_recall_end;
    t_cell_ctrl          w_ctrl;
    logic [RW-1:0]       w_row_b;
    logic [NEURONS-1:0]  w_clip;
    logic signed [TW-1:0] w_term [NEURONS];
    logic                w_sum_vld;
    logic [RW-1:0]       w_sum_tag;
    logic signed [SW-1:0] w_sum;
    logic                w_bit;

    // Number of neurons in use, clamped to 1..NEURONS, and its bit mask.
    always_comb begin
        w_live = r_active;
        if (r_active == '0) begin
            w_live = ACTIVE_W'(1);
        end else if (r_active > ACTIVE_W'(NEURONS)) begin
            w_live = ACTIVE_W'(NEURONS);
        end
    end

    assign w_n = CW'(w_live);

    always_comb begin
        for (int k = 0; k < NEURONS; k++) begin
            w_mask[k] = (ACTIVE_W'(k) < w_live);
        end
    end

    assign w_pat = i_pattern_bits[NEURONS-1:0] & w_mask;
    assign w_acc = start && (r_state == ST_IDLE);
    assign w_op  = t_op'(i_operation);

    // Sequencer outputs: row issue, cell control and end conditions.
    always_comb begin
        w_clearing = 1'b0;
        w_issue    = 1'b0;
        unique case (r_state)
            ST_INIT, ST_CLEAR: begin
                w_clearing = 1'b1;
            end
            ST_STORE: begin
                w_issue = (r_iss < w_n);
            end
            ST_RECALL: begin
                w_issue = (r_iss < w_n) && ((r_mode == MODE_SYNC) || (r_iss == r_got));
            end
            default: begin
                w_issue = 1'b0;
            end
        endcase

        w_ctrl.clr    = w_clearing;
        w_ctrl.store  = r_b_vld && (r_state == ST_STORE);
        w_ctrl.recall = r_b_vld && (r_state == ST_RECALL);
        w_ctrl.p_row  = r_b_p;
        w_row_b       = w_clearing ? r_iss[RW-1:0] : r_b_row;

        w_clear_last = w_clearing && (r_iss[RW-1:0] == RW'(NEURONS - 1));
        w_store_end  = (r_state == ST_STORE) && (r_iss == w_n) && !r_b_vld;
        w_sweep_end  = (r_state == ST_RECALL) && (r_got == w_n);
        w_recall_end = w_sweep_end && (r_sweep == (r_sweeps - SWEEP_W'(1)));
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_INIT, ST_CLEAR: begin
                if (w_clear_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_acc) begin
                    unique case (w_op)
                        OP_CLEAR:  n_state = ST_CLEAR;
                        OP_STORE:  n_state = ST_STORE;
                        OP_RECALL: n_state = (r_sweeps == '0) ? ST_IDLE : ST_RECALL;
                        OP_NOP:    n_state = ST_IDLE;
                    endcase
                end
            end
            ST_STORE: begin
                if (w_store_end) begin
                    n_state = ST_IDLE;
                end
            end
            ST_RECALL: begin
                if (w_recall_end) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_INIT;
            end
        endcase
    end

    // Row of neuron cells, one weight column each.
    for (genvar j = 0; j < NEURONS; j++) begin : g_cell
        hop_cell #(
            .NEURONS     (NEURONS),
            .WEIGHT_BITS (WEIGHT_BITS),
            .INDEX       (j)
        ) u_cell (
            .i_clk    (i_clk),
            .i_ctrl   (w_ctrl),
            .i_rd_row (r_iss[RW-1:0]),
            .i_row_b  (w_row_b),
            .i_active (w_mask[j]),
            .i_p_bit  (r_p[j]),
            .i_s_bit  (r_s[j]),
            .o_term   (w_term[j]),
            .o_clip   (w_clip[j])
        );
    end

    hop_sum_tree #(
        .NEURONS     (NEURONS),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_tree (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_c_vld),
        .i_tag   (r_c_row),
        .i_terms (w_term),
        .o_vld   (w_sum_vld),
        .o_tag   (w_sum_tag),
        .o_sum   (w_sum)
    );

    // A neuron fires when its drive is at least zero.
    assign w_bit = ~w_sum[SW-1];

    // Control registers, configuration and counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_INIT;
            r_active <= ACTIVE_RESET;
            r_sweeps <= SWEEPS_RESET;
            r_mode   <= MODE_ASYNC;
            r_iss    <= '0;
            r_got    <= '0;
            r_sweep  <= '0;
            r_b_vld  <= 1'b0;
            r_c_vld  <= 1'b0;
            r_count  <= '0;
            r_clip   <= 1'b0;
            r_stb    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_stb   <= 1'b0;
            r_b_vld <= w_issue;
            r_c_vld <= w_ctrl.recall;

            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_ACTIVE: r_active <= i_cfg_data[ACTIVE_W-1:0];
                    CFG_SWEEPS: r_sweeps <= i_cfg_data[SWEEP_W-1:0];
                    CFG_MODE:   r_mode   <= i_cfg_data[0];
                    default:    r_mode   <= r_mode;
                endcase
            end

            if (w_issue || w_clearing) begin
                r_iss <= r_iss + CW'(1);
            end
            if (w_clear_last) begin
                r_iss <= '0;
                r_stb <= (r_state == ST_CLEAR);
            end

            // New transaction.
            if (w_acc) begin
                r_iss   <= '0;
                r_got   <= '0;
                r_sweep <= '0;
                unique case (w_op)
                    OP_CLEAR: begin
                        r_count <= '0;
                        r_clip  <= 1'b0;
                    end
                    OP_STORE: begin
                        r_stb <= 1'b0;
                    end
                    OP_RECALL: begin
                        r_stb <= (r_sweeps == '0);
                    end
                    OP_NOP: begin
                        r_stb <= 1'b1;
                    end
                endcase
            end

            // Store: collect clipping and count the pattern at the end.
            if (w_ctrl.store && (|w_clip)) begin
                r_clip <= 1'b1;
            end
            if (w_store_end) begin
                if (r_count != {COUNT_W{1'b1}}) begin
                    r_count <= r_count + COUNT_W'(1);
                end
                r_stb <= 1'b1;
            end

            // Recall: count finished neurons and advance sweeps.
            if (w_sum_vld) begin
                r_got <= r_got + CW'(1);
            end
            if (w_sweep_end) begin
                r_iss   <= '0;
                r_got   <= '0;
                r_sweep <= r_sweep + SWEEP_W'(1);
                if (w_recall_end) begin
                    r_stb <= 1'b1;
                end
            end
        end
    end

    // Payload registers: patterns, neuron states and pipeline row tags.
    always_ff @(posedge i_clk) begin
        r_b_row <= r_iss[RW-1:0];
        r_b_p   <= r_p[r_iss[RW-1:0]];
        r_c_row <= r_b_row;

        if (w_acc) begin
            r_p   <= w_pat;
            r_s   <= w_pat;
            r_nx  <= '0;
            r_res <= w_pat;
        end else begin
            if (w_sum_vld) begin
                if (r_mode == MODE_SYNC) begin
                    r_nx[w_sum_tag] <= w_bit;
                end else begin
                    r_s[w_sum_tag] <= w_bit;
                end
            end
            if (w_sweep_end) begin
                r_nx <= '0;
                if (r_mode == MODE_SYNC) begin
                    r_s <= r_nx;
                end
                if (w_recall_end) begin
                    r_res <= (r_mode == MODE_SYNC) ? r_nx : r_s;
                end
            end
        end
    end

    assign busy               = (r_state != ST_IDLE);
    assign o_done             = r_stb;
    assign o_result_bits      = PAT_W'(r_res);
    assign o_patterns_stored  = r_count;
    assign o_weight_saturated = r_clip;

endmodule

// ----- rtl/hop_checker.sv -----
// Port-level checker of the associative memory top level, attached by bind.
// Depends on hop_pkg and hopfield_associative_memory_top_assert.svh.
`timescale 1ns / 1ps

`include "hopfield_associative_memory_top_assert.svh"

module hop_checker import hop_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  start,
    input logic                  busy,
    input logic [OP_W-1:0]       i_operation,
    input logic                  o_done,
    input logic [COUNT_W-1:0]    o_patterns_stored,
    input logic                  o_weight_saturated
);

    // A result is never shown while a transaction is still running.
    `HOP_ASSERT_SAME(a_done_idle, o_done, !busy, "result strobe while busy")

    // An accepted transaction either keeps the block busy or answers at once.
    `HOP_ASSERT_NEXT(a_accept_progress, start && !busy, busy || o_done, "accepted transaction lost")

    // Without a new transaction the stored count and clip flag stay put.
    `HOP_ASSERT_NEXT(a_idle_stable, !busy && !start, $stable(o_patterns_stored) && $stable(o_weight_saturated), "status changed while idle")

    // A clear resets the count and the clip flag right away.
    `HOP_ASSERT_NEXT(a_clear_status, start && !busy && (i_operation == OP_CLEAR), (o_patterns_stored == '0) && !o_weight_saturated, "clear did not reset status")

endmodule

bind hopfield_associative_memory_top hop_checker u_hop_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .start              (start),
    .busy               (busy),
    .i_operation        (i_operation),
    .o_done             (o_done),
    .o_patterns_stored  (o_patterns_stored),
    .o_weight_saturated (o_weight_saturated)
);
